/* hdl/ins_sort_pkg.sv */
// Shared constants and types of the insertion sorter.
package ins_sort_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_PUT,
    ST_EMIT_RD,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [VALUE_W-1:0] wdata;
    logic               re;
    logic [IDX_W-1:0]   raddr;
  } store_req_t;

endpackage

/* hdl/ins_sort_if.sv */
// Input and output channel interfaces of the insertion sorter.
interface ins_sort_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [ins_sort_pkg::VALUE_W-1:0]   value;
  logic                                      final_item;

  modport source (output valid, output value, output final_item, input ready);
  modport sink (input valid, input value, input final_item, output ready);
endinterface

interface ins_sort_out_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [ins_sort_pkg::VALUE_W-1:0]   sorted_value;
  logic                                      run_end;
  logic                                      overflowed;

  modport source (output valid, output sorted_value, output run_end, output overflowed,
                  input ready);
  modport sink (input valid, input sorted_value, input run_end, input overflowed,
                output ready);
endinterface

/* hdl/ins_sort_store.sv */
// Ordered value store: one write port, one registered read port.
module ins_sort_store (
  input  logic                              clk_i,
  input  ins_sort_pkg::store_req_t          req_i,
  output logic [ins_sort_pkg::VALUE_W-1:0]  rd_data_o
);

  logic [ins_sort_pkg::VALUE_W-1:0] mem_q [ins_sort_pkg::CAPACITY];
  logic [ins_sort_pkg::VALUE_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem_q[req_i.raddr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

/* hdl/ins_sort_ctrl.sv */
// Sequencer with the shared comparator, fill count and output register.
module ins_sort_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  ins_sort_in_if.sink                       in_i,
  ins_sort_out_if.source                    out_o,
  input  logic [ins_sort_pkg::VALUE_W-1:0]  rd_data_i,
  output ins_sort_pkg::store_req_t          req_o
);

  localparam int unsigned CntW = ins_sort_pkg::CNT_W;
  localparam int unsigned IdxW = ins_sort_pkg::IDX_W;
  localparam int unsigned ValW = ins_sort_pkg::VALUE_W;

  ins_sort_pkg::state_e state_q, state_d;

  logic [CntW-1:0]        pos_q, pos_d;
  logic [CntW-1:0]        fill_q, fill_d;
  logic [CntW-1:0]        k_q, k_d;
  logic                   ovf_q, ovf_d;
  logic                   last_q, last_d;
  logic signed [ValW-1:0] val_q, val_d;

  logic                   out_valid_q, out_valid_d;
  logic signed [ValW-1:0] out_val_q, out_val_d;
  logic                   out_end_q, out_end_d;
  logic                   out_ovf_q, out_ovf_d;

  logic            accept;
  logic            has_room;
  logic            greater;
  logic            pos_is_one;
  logic            load;
  logic            last_k;
  logic [CntW-1:0] fill_m1;
  logic [CntW-1:0] pos_m1;
  logic [CntW-1:0] pos_m2;
  logic [CntW-1:0] k_p1;

  assign accept     = in_i.valid && in_i.ready;
  assign has_room   = fill_q < CntW'(ins_sort_pkg::CAPACITY);
  assign greater    = $signed(rd_data_i) > val_q;
  assign pos_is_one = pos_q == CntW'(1);
  assign fill_m1    = fill_q - CntW'(1);
  assign pos_m1     = pos_q - CntW'(1);
  assign pos_m2     = pos_q - CntW'(2);
  assign k_p1       = k_q + CntW'(1);
  assign last_k     = k_q == fill_m1;
  assign load       = (state_q == ins_sort_pkg::ST_EMIT) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ins_sort_pkg::ST_IDLE: begin
        if (accept) begin
          if (has_room) begin
            state_d = (fill_q == '0) ? ins_sort_pkg::ST_PUT : ins_sort_pkg::ST_CMP;
          end else if (in_i.final_item) begin
            state_d = ins_sort_pkg::ST_EMIT_RD;
          end
        end
      end
      ins_sort_pkg::ST_CMP: begin
        if (greater) begin
          if (pos_is_one) begin
            state_d = ins_sort_pkg::ST_PUT;
          end
        end else begin
          state_d = last_q ? ins_sort_pkg::ST_EMIT_RD : ins_sort_pkg::ST_IDLE;
        end
      end
      ins_sort_pkg::ST_PUT: begin
        state_d = last_q ? ins_sort_pkg::ST_EMIT_RD : ins_sort_pkg::ST_IDLE;
      end
      ins_sort_pkg::ST_EMIT_RD: begin
        state_d = ins_sort_pkg::ST_EMIT;
      end
      ins_sort_pkg::ST_EMIT: begin
        if (load && last_k) begin
          state_d = ins_sort_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ins_sort_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    pos_d       = pos_q;
    fill_d      = fill_q;
    k_d         = k_q;
    ovf_d       = ovf_q;
    last_d      = last_q;
    val_d       = val_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_val_d   = out_val_q;
    out_end_d   = out_end_q;
    out_ovf_d   = out_ovf_q;
    req_o       = '0;
    in_i.ready  = state_q == ins_sort_pkg::ST_IDLE;
    case (state_q)
      ins_sort_pkg::ST_IDLE: begin
        if (accept) begin
          val_d  = in_i.value;
          last_d = in_i.final_item;
          pos_d  = fill_q;
          if (has_room) begin
            req_o.re    = fill_q != '0;
            req_o.raddr = fill_m1[IdxW-1:0];
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      ins_sort_pkg::ST_CMP: begin
        req_o.we = 1'b1;
        req_o.waddr = pos_q[IdxW-1:0];
        if (greater) begin
          req_o.wdata = rd_data_i;
          pos_d       = pos_m1;
          req_o.re    = !pos_is_one;
          req_o.raddr = pos_m2[IdxW-1:0];
        end else begin
          req_o.wdata = val_q;
          fill_d      = fill_q + CntW'(1);
        end
      end
      ins_sort_pkg::ST_PUT: begin
        req_o.we    = 1'b1;
        req_o.waddr = pos_q[IdxW-1:0];
        req_o.wdata = val_q;
        fill_d      = fill_q + CntW'(1);
      end
      ins_sort_pkg::ST_EMIT_RD: begin
        req_o.re    = 1'b1;
        req_o.raddr = '0;
        k_d         = '0;
      end
      ins_sort_pkg::ST_EMIT: begin
        if (load) begin
          out_valid_d = 1'b1;
          out_val_d   = rd_data_i;
          out_end_d   = last_k;
          out_ovf_d   = ovf_q;
          if (last_k) begin
            fill_d = '0;
            ovf_d  = 1'b0;
          end else begin
            k_d         = k_p1;
            req_o.re    = 1'b1;
            req_o.raddr = k_p1[IdxW-1:0];
          end
        end
      end
      default: begin
        req_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ins_sort_pkg::ST_IDLE;
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    k_q       <= k_d;
    last_q    <= last_d;
    val_q     <= val_d;
    out_val_q <= out_val_d;
    out_end_q <= out_end_d;
    out_ovf_q <= out_ovf_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.sorted_value = out_val_q;
  assign out_o.run_end      = out_end_q;
  assign out_o.overflowed   = out_ovf_q;

endmodule

/* hdl/insertion_sorter_core.sv */
// Top level of the insertion sorter.
// Holds up to CAPACITY (16) signed words in ascending order; a new word is placed after any
// equal words, and words arriving when the store is full are dropped and flag the set as
// overflowed. The store is a single-port-read memory driven by one comparator under a small
// sequencer: an accepted word is compared with the held words from the largest down, each larger
// word it moves past being shifted up one place, and is then written in below them; no input is
// taken meanwhile. On a word marked final the run is emitted smallest first, one word per cycle
// while the sink is ready, with run_end on the largest; the set then clears. The output register
// lets the next set start while the last emitted word awaits the sink.
module insertion_sorter_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  ins_sort_in_if.sink    in_i,
  ins_sort_out_if.source out_o
);

  ins_sort_pkg::store_req_t          store_req;
  logic [ins_sort_pkg::VALUE_W-1:0]  store_rd_data;

  ins_sort_store u_store (
    .clk_i     (clk_i),
    .req_i     (store_req),
    .rd_data_o (store_rd_data)
  );

  ins_sort_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .out_o     (out_o),
    .rd_data_i (store_rd_data),
    .req_o     (store_req)
  );

endmodule

/* hdl/ins_sort_chk.sv */
// Port-level checks of the insertion sorter, bound to the top level.
module ins_sort_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic [ins_sort_pkg::VALUE_W-1:0]  sorted_value_i,
  input logic                              run_end_i,
  input logic                              overflowed_i
);

  logic out_take;
  assign out_take = out_valid_i && out_ready_i;

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(sorted_value_i)
      && $stable(run_end_i) && $stable(overflowed_i)))
    else $error("stalled output word changed");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && !run_end_i) |=> out_valid_i)
    else $error("run broke off before its end word");

  a_no_input_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !run_end_i) |-> !in_ready_i)
    else $error("input taken while a run is being emitted");

  a_ovf_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && !run_end_i) |=> (overflowed_i == $past(overflowed_i)))
    else $error("overflow flag changed within a run");

  a_ready_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && out_valid_i && !run_end_i) |-> 1'b0)
    else $error("word accepted in the middle of a run");

endmodule

bind insertion_sorter_core ins_sort_chk u_ins_sort_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .sorted_value_i (out_o.sorted_value),
  .run_end_i      (out_o.run_end),
  .overflowed_i   (out_o.overflowed)
);

/* sim/testbench.sv */
// Self-checking testbench for insertion_sorter_core with random sets, idling and back-pressure.
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic signed [ins_sort_pkg::VALUE_W-1:0] value;
    logic                                    fin;
    logic                                    wait_drain;
  } in_word_t;

  typedef struct {
    logic signed [ins_sort_pkg::VALUE_W-1:0] sorted_value;
    logic                                    run_end;
    logic                                    overflowed;
  } sorted_word_t;

  localparam logic signed [ins_sort_pkg::VALUE_W-1:0] TOP    = 32'h7fff_ffff;
  localparam logic signed [ins_sort_pkg::VALUE_W-1:0] BOTTOM = 32'h8000_0000;
  localparam int                                      ITEMS  = 180;

  logic clk_i = 1'b0;
  logic rst_ni;

  ins_sort_in_if  in_bus ();
  ins_sort_out_if out_bus ();

  insertion_sorter_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #2 clk_i = ~clk_i;

  in_word_t                                pending[$];
  sorted_word_t                            sorted_due[$];
  logic signed [ins_sort_pkg::VALUE_W-1:0] held[ins_sort_pkg::CAPACITY];
  int                                      held_cnt = 0;
  logic                                    spilled = 1'b0;
  logic                                    calm = 1'b0;
  int                                      errors = 0;
  int                                      words_sent = 0;
  int                                      words_checked = 0;
  int                                      sets_done = 0;
  int                                      overflow_sets = 0;
  int                                      src_gap = 0;
  int                                      sink_hold = 0;
  logic                                    long_hold_done = 1'b0;

  // Place a word in the shadow store; on the final word release the whole run.
  function automatic void place_word(logic signed [ins_sort_pkg::VALUE_W-1:0] v, logic fin);
    int pos;
    sorted_word_t w;
    if (held_cnt < ins_sort_pkg::CAPACITY) begin
      pos = held_cnt;
      while (pos > 0 && held[pos-1] > v) begin
        held[pos] = held[pos-1];
        pos--;
      end
      held[pos] = v;
      held_cnt++;
    end else begin
      spilled = 1'b1;
    end
    if (fin) begin
      for (int k = 0; k < held_cnt; k++) begin
        w.sorted_value = held[k];
        w.run_end      = (k == held_cnt - 1);
        w.overflowed   = spilled;
        sorted_due.push_back(w);
      end
      sets_done++;
      if (spilled) overflow_sets++;
      held_cnt = 0;
      spilled  = 1'b0;
    end
  endfunction

  function automatic void queue_word(logic signed [ins_sort_pkg::VALUE_W-1:0] v, logic fin,
                                     logic drain);
    in_word_t w;
    w.value      = v;
    w.fin        = fin;
    w.wait_drain = drain;
    pending.push_back(w);
  endfunction

  function automatic logic signed [ins_sort_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return TOP;
      1:       return BOTTOM;
      2, 3:    return int'($urandom_range(0, 6)) - 3;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk_i) begin
    logic go;
    in_word_t w;
    if (rst_ni) begin
      go = in_bus.valid;
      if (in_bus.valid && in_bus.ready) begin
        place_word(in_bus.value, in_bus.final_item);
        words_sent++;
        go = 1'b0;
      end
      calm = (pending.size() < 30);
      if (!go) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending.size() > 0 &&
                     !(pending[0].wait_drain && sorted_due.size() > 0)) begin
          if (!calm && $urandom_range(0, 5) == 0) begin
            src_gap = $urandom_range(1, 6) - 1;
          end else begin
            w = pending.pop_front();
            in_bus.value      <= w.value;
            in_bus.final_item <= w.fin;
            go = 1'b1;
          end
        end
      end
      in_bus.valid <= go;
    end
  end

  always @(posedge clk_i) begin
    logic rdy;
    sorted_word_t w;
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        if (sorted_due.size() == 0) begin
          $error("unexpected word: sorted_value %0d run_end %0b overflowed %0b",
                 out_bus.sorted_value, out_bus.run_end, out_bus.overflowed);
          errors++;
        end else begin
          w = sorted_due.pop_front();
          words_checked++;
          if (out_bus.sorted_value !== w.sorted_value) begin
            $error("sorted_value: expected %0d, got %0d", w.sorted_value, out_bus.sorted_value);
            errors++;
          end
          if (out_bus.run_end !== w.run_end) begin
            $error("run_end: expected %0b, got %0b", w.run_end, out_bus.run_end);
            errors++;
          end
          if (out_bus.overflowed !== w.overflowed) begin
            $error("overflowed: expected %0b, got %0b", w.overflowed, out_bus.overflowed);
            errors++;
          end
        end
      end
      // hold the sink off long enough for the input to back up
      if (!long_hold_done && words_checked >= 30) begin
        long_hold_done = 1'b1;
        sink_hold = 300;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        rdy = 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        sink_hold = $urandom_range(1, 6) - 1;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_bus.ready <= rdy;
    end
  end

  initial begin
    int n;
    int total;
    logic drain;
    rst_ni             = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.value       = '0;
    in_bus.final_item  = 1'b0;
    out_bus.ready      = 1'b0;

    queue_word(0, 1'b1, 1'b0);
    queue_word(TOP, 1'b0, 1'b0);
    queue_word(BOTTOM, 1'b0, 1'b0);
    queue_word(-1, 1'b0, 1'b0);
    queue_word(0, 1'b0, 1'b0);
    queue_word(1, 1'b0, 1'b0);
    queue_word(1, 1'b1, 1'b0);
    for (int i = 0; i <= ins_sort_pkg::CAPACITY; i++)
      queue_word(100 - 10 * i, i == ins_sort_pkg::CAPACITY, i == 0);

    total = pending.size();
    while (total < ITEMS) begin
      case ($urandom_range(0, 9))
        0:       n = ins_sort_pkg::CAPACITY;
        1:       n = $urandom_range(ins_sort_pkg::CAPACITY + 1, ins_sort_pkg::CAPACITY + 4);
        2:       n = 1;
        default: n = $urandom_range(2, ins_sort_pkg::CAPACITY - 1);
      endcase
      drain = ($urandom_range(0, 7) == 0);
      for (int k = 0; k < n; k++)
        queue_word(pick_value(), k == n - 1, drain && k == 0);
      total += n;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending.size() == 0 && !in_bus.valid);
    wait (sorted_due.size() == 0);
    repeat (40) @(posedge clk_i);

    $display("Sent %0d input words in %0d sets, %0d of them overflowed.",
             words_sent, sets_done, overflow_sets);
    $display("Checked %0d sorted words against the shadow store.", words_checked);
    if (errors == 0) begin
      $display("PASS insertion_sorter_core");
    end else begin
      $display("FAIL insertion_sorter_core");
    end
    $finish;
  end

  initial begin
    #200us;
    $display("FAIL insertion_sorter_core");
    $finish;
  end

endmodule

/* sim.f */
hdl/ins_sort_pkg.sv
hdl/ins_sort_if.sv
hdl/ins_sort_store.sv
hdl/ins_sort_ctrl.sv
hdl/insertion_sorter_core.sv
hdl/ins_sort_chk.sv
sim/testbench.sv
